### src/graphics_command_base64_decoder_top_defines.svh
// Assertion macros used by the graphics command base64 decoder checker.
`ifndef GRAPHICS_COMMAND_BASE64_DECODER_TOP_DEFINES_SVH
`define GRAPHICS_COMMAND_BASE64_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define GCBD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcbd assertion failed");

// Next-cycle implication, disabled during reset.
`define GCBD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcbd assertion failed");

`endif

### src/gcbd_pkg.sv
// Package: types, constants and helper functions of the graphics command base64 decoder.
`default_nettype none

package gcbd_pkg;

    localparam logic [3:0] MIN_DECODED_BYTES = 4'd8;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_KEYS,
        PH_PAYLOAD,
        PH_NOTGFX
    } phase_t;

    typedef enum logic [1:0] {
        PP_START,
        PP_SAW_F,
        PP_VALUE,
        PP_SKIP
    } pair_t;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NOTGFX      = 3'd1,
        ST_MISSING     = 3'd2,
        ST_UNSUPPORTED = 3'd3,
        ST_SHORT       = 3'd4
    } status_t;

    localparam logic [2:0] MATCH_FULL = 3'd3;
    localparam logic [2:0] MATCH_BAD  = 3'd4;

    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    typedef struct packed {
        logic       vld;
        logic [7:0] data;
        logic       enough;
    } b64_res_t;

    // Expected characters of the format value "100".
    function automatic logic [7:0] want_char(input logic [1:0] idx);
        return (idx == 2'd0) ? CH_ONE : CH_ZERO;
    endfunction

    // Sextet value in [5:0]; bit 6 set means skip the character.
    function automatic logic [6:0] sextet(input logic [7:0] c);
        logic [6:0] v;
        v = 7'h40;
        if (c >= 8'h41 && c <= 8'h5A)
            v = {1'b0, 6'(c - 8'h41)};
        else if (c >= 8'h61 && c <= 8'h7A)
            v = {1'b0, 6'(c - 8'h61 + 8'd26)};
        else if (c >= 8'h30 && c <= 8'h39)
            v = {1'b0, 6'(c - 8'h30 + 8'd52)};
        else if (c == 8'h2B || c == 8'h2D)
            v = 7'd62;
        else if (c == 8'h2F || c == 8'h5F)
            v = 7'd63;
        return v;
    endfunction

endpackage

`default_nettype wire

### src/gcbd_parse.sv
// Message parser: header check, key list scan for the format pair, final status.
`default_nettype none

module gcbd_parse (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic [7:0] in_byte,
    input  wire logic       last,
    input  wire logic       enough,
    output logic            decode_en,
    output logic [2:0]      status
);

    gcbd_pkg::phase_t phase_reg, phase_next;
    gcbd_pkg::pair_t  pair_reg, pair_next;
    logic             found_reg, found_next;
    logic [2:0]       match_reg, match_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= gcbd_pkg::PH_FIRST;
            pair_reg  <= gcbd_pkg::PP_START;
            found_reg <= 1'b0;
            match_reg <= 3'd0;
        end
        else if (step)
        begin
            if (last)
            begin
                phase_reg <= gcbd_pkg::PH_FIRST;
                pair_reg  <= gcbd_pkg::PP_START;
                found_reg <= 1'b0;
                match_reg <= 3'd0;
            end
            else
            begin
                phase_reg <= phase_next;
                pair_reg  <= pair_next;
                found_reg <= found_next;
                match_reg <= match_next;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        pair_next  = pair_reg;
        found_next = found_reg;
        match_next = match_reg;
        unique case (phase_reg)
            gcbd_pkg::PH_FIRST:
            begin
                phase_next = (in_byte == gcbd_pkg::CH_G) ? gcbd_pkg::PH_KEYS
                                                         : gcbd_pkg::PH_NOTGFX;
            end
            gcbd_pkg::PH_KEYS:
            begin
                if (in_byte == gcbd_pkg::CH_SEMI)
                    phase_next = gcbd_pkg::PH_PAYLOAD;
                else if (in_byte == gcbd_pkg::CH_COMMA)
                    pair_next = found_reg ? gcbd_pkg::PP_SKIP : gcbd_pkg::PP_START;
                else
                begin
                    unique case (pair_reg)
                        gcbd_pkg::PP_START:
                        begin
                            pair_next = (in_byte == gcbd_pkg::CH_F) ? gcbd_pkg::PP_SAW_F
                                                                    : gcbd_pkg::PP_SKIP;
                        end
                        gcbd_pkg::PP_SAW_F:
                        begin
                            if (in_byte == gcbd_pkg::CH_EQ)
                            begin
                                found_next = 1'b1;
                                match_next = 3'd0;
                                pair_next  = gcbd_pkg::PP_VALUE;
                            end
                            else
                                pair_next = gcbd_pkg::PP_SKIP;
                        end
                        gcbd_pkg::PP_VALUE:
                        begin
                            if (match_reg < gcbd_pkg::MATCH_FULL &&
                                in_byte == gcbd_pkg::want_char(match_reg[1:0]))
                                match_next = match_reg + 3'd1;
                            else
                                match_next = gcbd_pkg::MATCH_BAD;
                        end
                        gcbd_pkg::PP_SKIP:
                        begin
                            pair_next = pair_reg;
                        end
                    endcase
                end
            end
            gcbd_pkg::PH_PAYLOAD,
            gcbd_pkg::PH_NOTGFX:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    assign decode_en = (phase_reg == gcbd_pkg::PH_PAYLOAD) && found_reg &&
                       (match_reg == gcbd_pkg::MATCH_FULL);

    // A message that ends on its first byte is never a graphics message.
    always_comb
    begin
        priority if (phase_reg == gcbd_pkg::PH_FIRST || phase_next == gcbd_pkg::PH_NOTGFX)
            status = gcbd_pkg::ST_NOTGFX;
        else if (!found_next)
            status = gcbd_pkg::ST_MISSING;
        else if (match_next != gcbd_pkg::MATCH_FULL)
            status = gcbd_pkg::ST_UNSUPPORTED;
        else if (!enough)
            status = gcbd_pkg::ST_SHORT;
        else
            status = gcbd_pkg::ST_OK;
    end

endmodule

`default_nettype wire

### src/gcbd_b64.sv
// Base64 sextet decode, bit accumulator and decoded byte counter.
`default_nettype none

module gcbd_b64 #(
    parameter logic [3:0] MIN_DECODED_BYTES = gcbd_pkg::MIN_DECODED_BYTES
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire logic       decode_en,
    input  wire logic [7:0] in_byte,
    input  wire logic       last,
    output gcbd_pkg::b64_res_t res
);

    logic [11:0] buf_reg, buf_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [3:0]  count_reg, count_next;
    logic [6:0]  sx;
    logic [3:0]  sum;

    assign sx  = gcbd_pkg::sextet(in_byte);
    assign sum = {1'b0, cnt_reg} + 4'd6;

    always_comb
    begin
        buf_next   = buf_reg;
        cnt_next   = cnt_reg;
        count_next = count_reg;
        res.vld    = 1'b0;
        res.data   = 8'd0;
        if (decode_en && !sx[6])
        begin
            buf_next = {buf_reg[5:0], sx[5:0]};
            cnt_next = sum[2:0];
            if (sum[3])
            begin
                res.vld  = 1'b1;
                res.data = 8'(buf_next >> cnt_next);
                if (count_reg < MIN_DECODED_BYTES)
                    count_next = count_reg + 4'd1;
            end
        end
        res.enough = (count_next >= MIN_DECODED_BYTES);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg   <= 12'd0;
            cnt_reg   <= 3'd0;
            count_reg <= 4'd0;
        end
        else if (step)
        begin
            if (last)
            begin
                buf_reg   <= 12'd0;
                cnt_reg   <= 3'd0;
                count_reg <= 4'd0;
            end
            else
            begin
                buf_reg   <= buf_next;
                cnt_reg   <= cnt_next;
                count_reg <= count_next;
            end
        end
    end

endmodule

`default_nettype wire

### src/graphics_command_base64_decoder_top.sv
// Top level of the graphics command base64 decoder.
// Takes one message byte per cycle unless the output register is stalled ("G", key=value list,
// ";", base64 payload, last flag on the final byte), emits each decoded payload byte and a
// status on the last byte. Throughput is one byte per cycle while out_ready allows: each byte
// waits in the input register while the parser and base64 accumulator update, and its result,
// if it has one, lands in the output register. in_ready drops only when the input register
// holds a byte while the output register is occupied and stalled.
`default_nettype none

module graphics_command_base64_decoder_top #(
    parameter logic [3:0] MIN_DECODED_BYTES = gcbd_pkg::MIN_DECODED_BYTES
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic            byte_valid,
    output logic            done_res,
    output logic [2:0]      status
);

    logic       in_v_reg;
    logic [7:0] in_byte_reg;
    logic       last_reg;
    logic       out_v_reg;
    logic [7:0] out_byte_reg;
    logic       byte_valid_reg;
    logic       done_reg;
    logic [2:0] status_reg;

    logic       advance;
    logic       produce;
    logic       decode_en;
    logic [2:0] st;
    gcbd_pkg::b64_res_t res;

    assign advance  = in_v_reg && (!out_v_reg || out_ready);
    assign in_ready = !in_v_reg || !out_v_reg || out_ready;
    assign produce  = advance && (res.vld || last_reg);

    gcbd_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .in_byte   (in_byte_reg),
        .last      (last_reg),
        .enough    (res.enough),
        .decode_en (decode_en),
        .status    (st)
    );

    gcbd_b64 #(
        .MIN_DECODED_BYTES (MIN_DECODED_BYTES)
    ) u_b64 (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .decode_en (decode_en),
        .in_byte   (in_byte_reg),
        .last      (last_reg),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                in_v_reg <= 1'b1;
            else if (advance)
                in_v_reg <= 1'b0;

            if (produce)
                out_v_reg <= 1'b1;
            else if (out_ready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
            last_reg    <= last;
        end
        if (produce)
        begin
            out_byte_reg   <= res.data;
            byte_valid_reg <= res.vld;
            done_reg       <= last_reg;
            status_reg     <= last_reg ? st : gcbd_pkg::ST_OK;
        end
    end

    assign out_valid  = out_v_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign done_res   = done_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

### src/gcbd_checker.sv
// Port-level checker for the graphics command base64 decoder, bound to the top level.
`default_nettype none
`include "graphics_command_base64_decoder_top_defines.svh"

module gcbd_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] out_byte,
    input wire logic       byte_valid,
    input wire logic       done_res,
    input wire logic [2:0] status
);

    // A stalled transaction holds.
    `GCBD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(byte_valid) && $stable(done_res) && $stable(status))
    // Every result carries a byte, a status, or both.
    `GCBD_ASSERT_IMPLY(a_out_nonempty, clk, rst_n, out_valid, byte_valid || done_res)
    // Status only on the last result of a message.
    `GCBD_ASSERT_IMPLY(a_status_done, clk, rst_n, out_valid && !done_res, status == 3'd0)
    // No data byte means a zero data field.
    `GCBD_ASSERT_IMPLY(a_byte_zero, clk, rst_n, out_valid && !byte_valid, out_byte == 8'd0)

endmodule

bind graphics_command_base64_decoder_top gcbd_checker u_gcbd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .byte_valid (byte_valid),
    .done_res   (done_res),
    .status     (status)
);

`default_nettype wire

### tb/tb_graphics_command_base64_decoder_top.sv
// Testbench for the graphics command base64 decoder: random and directed messages, scoreboard.
`timescale 1ns / 100ps

module tb_graphics_command_base64_decoder_top;

    import gcbd_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_AT     = 1300;
    localparam int HOLD_LEN    = 400;
    localparam int DRAIN_WAIT  = 10;

    typedef struct packed {
        logic [7:0] b;
        logic       l;
    } msg_byte_t;

    typedef struct packed {
        logic [7:0] data;
        logic       dv;
        logic       done;
        logic [2:0] st;
    } dec_result_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] in_byte   = 8'h00;
    logic       last      = 1'b0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       done_res;
    logic [2:0] status;

    msg_byte_t   pend_q[$];
    dec_result_t exp_q[$];
    logic [7:0]  msg_buf[$];

    int n_err     = 0;
    int n_queued  = 0;
    int n_sent    = 0;
    int n_cycles  = 0;
    int snd_idle  = 28;
    int rcv_idle  = 47;
    int hold_left = 0;
    logic hold_done = 1'b0;
    dec_result_t want;

    // decoder state as tracked by the scoreboard
    phase_t     m_phase = PH_FIRST;
    pair_t      m_pair  = PP_START;
    logic       m_found = 1'b0;
    logic [2:0] m_match = 3'd0;
    logic [11:0] m_acc  = 12'd0;
    logic [2:0] m_nbits = 3'd0;
    logic [3:0] m_ndec  = 4'd0;

    graphics_command_base64_decoder_top uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .done_res   (done_res),
        .status     (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        n_err++;
    endtask

    // Advance the tracked state by one message byte and queue the result it causes.
    task automatic decode_byte(input logic [7:0] c, input logic lst);
        int sx;
        logic hit;
        logic [7:0] ob;
        status_t st;
        dec_result_t r;
        hit = 1'b0;
        ob  = 8'h00;
        st  = ST_OK;
        sx  = -1;
        case (m_phase)
            PH_FIRST: m_phase = (c == CH_G) ? PH_KEYS : PH_NOTGFX;
            PH_KEYS:
            begin
                if (c == CH_SEMI)
                    m_phase = PH_PAYLOAD;
                else if (c == CH_COMMA)
                    m_pair = m_found ? PP_SKIP : PP_START;
                else
                begin
                    case (m_pair)
                        PP_START: m_pair = (c == CH_F) ? PP_SAW_F : PP_SKIP;
                        PP_SAW_F:
                        begin
                            if (c == CH_EQ)
                            begin
                                m_found = 1'b1;
                                m_match = 3'd0;
                                m_pair  = PP_VALUE;
                            end
                            else
                                m_pair = PP_SKIP;
                        end
                        PP_VALUE:
                        begin
                            if (m_match < MATCH_FULL &&
                                c == ((m_match == 3'd0) ? CH_ONE : CH_ZERO))
                                m_match = m_match + 3'd1;
                            else
                                m_match = MATCH_BAD;
                        end
                        default: ;
                    endcase
                end
            end
            PH_PAYLOAD:
            begin
                if (m_found && m_match == MATCH_FULL)
                begin
                    if (c >= "A" && c <= "Z")
                        sx = int'(c) - "A";
                    else if (c >= "a" && c <= "z")
                        sx = int'(c) - "a" + 26;
                    else if (c >= "0" && c <= "9")
                        sx = int'(c) - "0" + 52;
                    else if (c == "+" || c == "-")
                        sx = 62;
                    else if (c == "/" || c == "_")
                        sx = 63;
                    if (sx >= 0)
                    begin
                        m_acc = {m_acc[5:0], 6'(sx)};
                        if (m_nbits >= 3'd2)
                        begin
                            m_nbits = m_nbits - 3'd2;
                            ob  = 8'(m_acc >> m_nbits);
                            hit = 1'b1;
                            if (m_ndec < MIN_DECODED_BYTES)
                                m_ndec = m_ndec + 4'd1;
                        end
                        else
                            m_nbits = m_nbits + 3'd6;
                    end
                end
            end
            default: ;
        endcase
        if (lst)
        begin
            if (m_phase == PH_FIRST || m_phase == PH_NOTGFX)
                st = ST_NOTGFX;
            else if (!m_found)
                st = ST_MISSING;
            else if (m_match != MATCH_FULL)
                st = ST_UNSUPPORTED;
            else if (m_ndec < MIN_DECODED_BYTES)
                st = ST_SHORT;
            else
                st = ST_OK;
            // lone 'G' message
            if (m_phase == PH_KEYS && m_pair == PP_START && !m_found && c == CH_G)
                st = ST_NOTGFX;
        end
        if (hit || lst)
        begin
            r.data = ob;
            r.dv   = hit;
            r.done = lst;
            r.st   = st;
            exp_q.push_back(r);
        end
        if (lst)
        begin
            m_phase = PH_FIRST;
            m_pair  = PP_START;
            m_found = 1'b0;
            m_match = 3'd0;
            m_acc   = 12'd0;
            m_nbits = 3'd0;
            m_ndec  = 4'd0;
        end
    endtask

    task automatic add(input logic [7:0] b);
        msg_buf.push_back(b);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            add(s[i]);
    endtask

    task automatic end_msg();
        msg_byte_t it;
        for (int i = 0; i < msg_buf.size(); i++)
        begin
            it.b = msg_buf[i];
            it.l = (i == msg_buf.size() - 1);
            pend_q.push_back(it);
        end
        n_queued += msg_buf.size();
        msg_buf.delete();
    endtask

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(35);
        return (r < 26) ? 8'h61 + 8'(r) : 8'h30 + 8'(r - 26);
    endfunction

    // n payload characters, both alphabets, with skipped characters mixed in
    task automatic add_b64(input int n);
        int v;
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 3)
                add(8'($urandom_range(255)));
            else if (r < 7)
            begin
                case ($urandom_range(3))
                    0: add(CH_EQ);
                    1: add(" ");
                    2: add(8'h0A);
                    default: add(8'h09);
                endcase
            end
            v = $urandom_range(63);
            if (v < 26)
                add(8'h41 + 8'(v));
            else if (v < 52)
                add(8'h61 + 8'(v - 26));
            else if (v < 62)
                add(8'h30 + 8'(v - 52));
            else if (v == 62)
                add(($urandom_range(1) != 0) ? "+" : "-");
            else
                add(($urandom_range(1) != 0) ? "/" : "_");
        end
    endtask

    task automatic add_pair(input logic f_key);
        logic [7:0] k;
        if (f_key)
            add(CH_F);
        else
        begin
            k = 8'h61 + 8'($urandom_range(25));
            add(k);
            if (k == CH_F)
                add(rand_alnum());
            if ($urandom_range(1) != 0)
                add(rand_alnum());
        end
        add(CH_EQ);
        repeat ($urandom_range(3))
            add(rand_alnum());
    endtask

    task automatic gen_message();
        int r;
        int rf;
        logic sep;
        r   = $urandom_range(99);
        sep = 1'b0;
        if (r < 68)
        begin
            add(CH_G);
            repeat ($urandom_range(2))
            begin
                if (sep)
                    add(CH_COMMA);
                add_pair(1'b0);
                sep = 1'b1;
            end
            rf = $urandom_range(99);
            if (rf >= 6)
            begin
                if (sep)
                    add(CH_COMMA);
                add(CH_F);
                add(CH_EQ);
                if (rf < 82)
                    add_str("100");
                else
                begin
                    case ($urandom_range(4))
                        0: ;
                        1: add_str("10");
                        2: add_str("1000");
                        3: add_str("101");
                        default: add(rand_alnum());
                    endcase
                end
                sep = 1'b1;
            end
            repeat ($urandom_range(2))
            begin
                if (sep)
                    add(CH_COMMA);
                add_pair($urandom_range(99) < 30);
                sep = 1'b1;
            end
            if ($urandom_range(99) < 5)
                add(CH_COMMA);
            if ($urandom_range(99) < 95)
                add(CH_SEMI);
            add_b64(($urandom_range(99) < 20) ? $urandom_range(10) : $urandom_range(24, 11));
        end
        else if (r < 80)
        begin
            add(($urandom_range(99) < 30) ? CH_G : 8'($urandom_range(255)));
            repeat ($urandom_range(9))
                add(8'($urandom_range(255)));
        end
        else if (r < 94)
        begin
            add(CH_G);
            repeat ($urandom_range(12, 1))
            begin
                case ($urandom_range(8))
                    0: add(CH_COMMA);
                    1: add(CH_F);
                    2: add(CH_EQ);
                    3: add(CH_ONE);
                    4: add(CH_ZERO);
                    5: add(CH_SEMI);
                    6: add(CH_G);
                    7: add(rand_alnum());
                    default: add(8'($urandom_range(255)));
                endcase
            end
        end
        else
            add(($urandom_range(1) != 0) ? CH_G : 8'($urandom_range(255)));
        end_msg();
    endtask

    task automatic run_phase(input int s_idle, input int r_idle, input int cnt);
        int start;
        snd_idle = s_idle;
        rcv_idle = r_idle;
        start    = n_queued;
        while (n_queued - start < cnt)
            gen_message();
        while (pend_q.size() != 0)
            @(negedge clk);
    endtask

    // input driver
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                decode_byte(in_byte, last);
                void'(pend_q.pop_front());
                n_sent <= n_sent + 1;
            end
            if (in_valid && !in_ready)
                ;
            else if (pend_q.size() != 0 && (hold_left != 0 || $urandom_range(99) >= snd_idle))
            begin
                in_valid <= 1'b1;
                in_byte  <= pend_q[0].b;
                last     <= pend_q[0].l;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output monitor and receiver backpressure
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (exp_q.size() == 0)
                    report_mismatch("result transaction with nothing expected");
                else
                begin
                    want = exp_q.pop_front();
                    if (out_byte !== want.data)
                        report_mismatch($sformatf("out_byte %02h, expected %02h",
                                                  out_byte, want.data));
                    if (byte_valid !== want.dv)
                        report_mismatch($sformatf("byte_valid %b, expected %b",
                                                  byte_valid, want.dv));
                    if (done_res !== want.done)
                        report_mismatch($sformatf("done_res %b, expected %b",
                                                  done_res, want.done));
                    if (status !== want.st)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  status, want.st));
                end
            end
            if (!hold_done && n_sent >= HOLD_AT)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_LEN;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        add(CH_G);                      // lone 'G'
        end_msg();
        add(8'hFF);                     // not starting with 'G'
        add(8'h00);
        end_msg();
        add_str("G;AAAA");              // no format key
        end_msg();
        add_str("Gf=;");                // empty format value
        end_msg();
        add_str("Gf=100;-_+/AZaz09w="); // both alphabets, padding, leftover bits
        end_msg();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_phase(28, 47, 550);
        run_phase(47, 28, 550);
        run_phase(0, 0, 550);

        while (exp_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);

        if (n_err == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### graphics_command_base64_decoder_top.f
+incdir+src
src/gcbd_pkg.sv
src/gcbd_parse.sv
src/gcbd_b64.sv
src/graphics_command_base64_decoder_top.sv
src/gcbd_checker.sv
tb/tb_graphics_command_base64_decoder_top.sv
